// ===== sv/psns_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psns_pkg
// Shared types, codes and helpers of the path node spline sampler.
// ----------------------------------------------------------------------------
package psns_pkg;

    // Command codes of an input word.
    localparam logic [1:0] CMD_APPEND = 2'd0;
    localparam logic [1:0] CMD_CLEAR  = 2'd1;
    localparam logic [1:0] CMD_QUERY  = 2'd2;

    // Status codes of a result word.
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    // Integer part of the Q12.12 query index.
    localparam int CIDX_W = 12;
    localparam int CCNT_W = 4;

    // Shared multiplier and accumulator widths.
    localparam int AW   = 39;
    localparam int BW   = 17;
    localparam int PW   = AW + BW;
    localparam int ACCW = 72;

    // Index of the last step of each sequence phase.
    localparam logic [4:0] LIN_LAST = 5'd2;
    localparam logic [4:0] CR_LAST  = 5'd23;
    localparam logic [4:0] WGT_LAST = 5'd5;

    localparam logic signed [ACCW-1:0] CR_RND  = ACCW'(1) << 36;
    localparam logic signed [ACCW-1:0] LIN_RND = ACCW'(2048);

    typedef struct packed {
        logic       acc;
        logic       clr;
        logic       sh;
        logic       last;
        logic [1:0] ax;
    } mac_ctl_t;

    function automatic logic [31:0] sat32(input logic signed [ACCW-1:0] v);
        logic signed [ACCW-1:0] hi;
        logic signed [ACCW-1:0] lo;
        hi = {{(ACCW-31){1'b0}}, {31{1'b1}}};
        lo = {{(ACCW-31){1'b1}}, {31{1'b0}}};
        if (v > hi) begin
            return 32'h7fff_ffff;
        end else if (v < lo) begin
            return 32'h8000_0000;
        end
        return v[31:0];
    endfunction

endpackage

// ===== sv/psns_mac.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psns_mac
// Shared signed multiplier with a registered product and an accumulator.
// ----------------------------------------------------------------------------
module psns_mac (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic signed [psns_pkg::AW-1:0]      mul_a,
    input  logic signed [psns_pkg::BW-1:0]      mul_b,
    input  psns_pkg::mac_ctl_t                  ctl_i,
    output logic signed [psns_pkg::PW-1:0]      prod_o,
    output logic signed [psns_pkg::ACCW-1:0]    acc_o,
    output psns_pkg::mac_ctl_t                  done_o
);

    logic signed [psns_pkg::PW-1:0]   prod_reg;
    logic signed [psns_pkg::ACCW-1:0] acc_reg;
    logic signed [psns_pkg::ACCW-1:0] addend;
    psns_pkg::mac_ctl_t               ctl_reg;
    psns_pkg::mac_ctl_t               done_reg;

    // The accumulate stage takes the product register in the following cycle.
    assign addend = ctl_reg.sh ? (psns_pkg::ACCW'(prod_reg) <<< 16)
                               : psns_pkg::ACCW'(prod_reg);

    always_ff @(posedge aclk) begin
        prod_reg <= mul_a * mul_b;
        if (ctl_reg.acc) begin
            acc_reg <= (ctl_reg.clr ? '0 : acc_reg) + addend;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl_reg  <= '0;
            done_reg <= '0;
        end else begin
            ctl_reg  <= ctl_i;
            done_reg <= ctl_reg;
        end
    end

    assign prod_o = prod_reg;
    assign acc_o  = acc_reg;
    assign done_o = done_reg;

endmodule

// ===== sv/psns_mod.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psns_mod
// Bit-serial remainder of the signed node index by the node count.
// ----------------------------------------------------------------------------
module psns_mod #(
    parameter int NW = 9
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 start,
    input  logic signed [psns_pkg::CIDX_W-1:0]   num,
    input  logic [NW-1:0]                        den,
    output logic                                 done_o,
    output logic [NW-1:0]                        rem_o
);

    logic                          run_reg;
    logic                          fin_reg;
    logic [psns_pkg::CCNT_W-1:0]   cnt_reg;
    logic [psns_pkg::CIDX_W-1:0]   mag_reg;
    logic [NW-1:0]                 rem_reg;
    logic                          neg_reg;
    logic [NW:0]                   sh;
    logic [NW:0]                   sh_next;

    always_comb begin
        sh      = {rem_reg, mag_reg[psns_pkg::CIDX_W-1]};
        sh_next = (sh >= {1'b0, den}) ? sh - {1'b0, den} : sh;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg <= 1'b0;
            fin_reg <= 1'b0;
            cnt_reg <= '0;
        end else begin
            fin_reg <= 1'b0;
            if (start) begin
                run_reg <= 1'b1;
                cnt_reg <= '0;
            end else if (run_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == psns_pkg::CCNT_W'(psns_pkg::CIDX_W - 1)) begin
                    run_reg <= 1'b0;
                    fin_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            neg_reg <= num[psns_pkg::CIDX_W-1];
            mag_reg <= num[psns_pkg::CIDX_W-1] ? psns_pkg::CIDX_W'(-num)
                                               : psns_pkg::CIDX_W'(num);
            rem_reg <= '0;
        end else if (run_reg) begin
            mag_reg <= {mag_reg[psns_pkg::CIDX_W-2:0], 1'b0};
            rem_reg <= sh_next[NW-1:0];
        end
    end

    // A negative index folds back from the top of the period.
    assign rem_o  = (neg_reg && rem_reg != '0) ? den - rem_reg : rem_reg;
    assign done_o = fin_reg;

endmodule

// ===== sv/path_node_spline_sampler.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// path_node_spline_sampler
// Waypoint table with linear and Catmull-Rom position queries.
// ----------------------------------------------------------------------------
// Usage:
// Words enter on the s_ channel (valid/ready) and every word returns exactly
// one result word on the m_ channel. An append stores a Q16.16 node at the
// end of the table, a clear empties it, and a query returns the position at
// a Q12.12 fractional node index. closed_path_we writes the path mode; the
// user must write it only while idle; the block does not enforce this.
// Sequencing: an append or clear goes straight to its result. A query that
// lands on a single node only fetches that node. A linear query and a
// Catmull-Rom query take their products on the single multiplier; the
// cubic weights take 5 products and the three axes then take 24 products.
// A closed path first runs the serial remainder of the index by the node
// count.
// One word is in work at a time and s_ready is low meanwhile. A finished
// result waits in the output register; the next word is accepted while the
// receiver stalls. After reset the table is empty and the path is open;
// the table contents are not cleared.
// ----------------------------------------------------------------------------
module path_node_spline_sampler #(
    parameter int MAX_NODES = 256
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               closed_path_we,
    input  logic               closed_path_wdata,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [1:0]         s_cmd,
    input  logic signed [31:0] s_node_x,
    input  logic signed [31:0] s_node_y,
    input  logic signed [31:0] s_node_z,
    input  logic signed [23:0] s_query_index,
    input  logic               s_linear_mode,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [31:0] m_pos_x,
    output logic signed [31:0] m_pos_y,
    output logic signed [31:0] m_pos_z,
    output logic [1:0]         m_status
);

    localparam int IW = $clog2(MAX_NODES);
    localparam int NW = $clog2(MAX_NODES + 1);

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_MOD   = 8'b0000_0010,
        S_NB    = 8'b0000_0100,
        S_FETCH = 8'b0000_1000,
        S_WGT   = 8'b0001_0000,
        S_AXIS  = 8'b0010_0000,
        S_DRAIN = 8'b0100_0000,
        S_DONE  = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;

    // Waypoint table, z:y:x per entry.
    logic [95:0]   mem [MAX_NODES];
    logic [95:0]   rdata_reg;
    logic [IW-1:0] rd_addr;

    logic [NW-1:0] count_reg;
    logic          closed_reg;

    logic [11:0]   t_reg;
    logic          lin_reg;
    logic          copy_reg;
    logic [IW-1:0] c_reg;
    logic [IW-1:0] nb_reg [4];
    logic [95:0]   p_reg [4];
    logic [2:0]    fcnt_reg;
    logic [4:0]    step_reg;

    logic [23:0]                     m1_reg;
    logic [23:0]                     m2_reg;
    logic signed [psns_pkg::AW-1:0]  t2u_reg;
    logic signed [psns_pkg::AW-1:0]  t3_reg;
    logic signed [psns_pkg::AW-1:0]  w_reg [4];

    logic [31:0] res_x_reg, res_y_reg, res_z_reg;
    logic [1:0]  res_st_reg;
    logic        m_valid_reg;

    logic                              accept;
    logic signed [31:0]                thr_w;
    logic signed [31:0]                idx_w;
    logic                              mod_start;
    logic                              mod_done;
    logic [NW-1:0]                     mod_rem;
    logic signed [psns_pkg::AW-1:0]    mac_a;
    logic signed [psns_pkg::BW-1:0]    mac_b;
    psns_pkg::mac_ctl_t                mac_ctl;
    logic signed [psns_pkg::PW-1:0]    mac_prod;
    logic signed [psns_pkg::ACCW-1:0]  mac_acc;
    psns_pkg::mac_ctl_t                mac_done;
    logic [2:0]                        nfetch;
    logic [12:0]                       u_w;
    logic [31:0]                       pk;
    logic [31:0]                       p0a;
    logic [31:0]                       p1a;
    logic signed [32:0]                dlin;
    logic [31:0]                       res_val;
    logic signed [40:0]                m1x, t3x, w1x, w2x;
    logic [IW-1:0]                     nb1, nb2, nb3;

    // Neighbour rule: step to the next node, wrap or hold at the end.
    function automatic logic [IW-1:0] nxt(input logic [IW-1:0] i, input logic [NW-1:0] n,
                                          input logic closed);
        logic [NW:0] ip1;
        ip1 = {1'b0, NW'(i)} + (NW+1)'(1);
        if (ip1 >= {1'b0, n}) begin
            return closed ? '0 : i;
        end
        return ip1[IW-1:0];
    endfunction

    assign s_ready = (state_reg == S_IDLE);
    assign accept  = s_valid && s_ready;
    assign thr_w   = signed'((32'(count_reg) - 32'd3) << 12);
    assign idx_w   = 32'(s_query_index);
    assign u_w     = 13'd4096 - {1'b0, t_reg};
    assign nfetch  = copy_reg ? 3'd1 : (lin_reg ? 3'd2 : 3'd4);
    assign rd_addr = nb_reg[fcnt_reg[1:0]];

    assign mod_start = accept && (s_cmd == psns_pkg::CMD_QUERY) && closed_reg
                       && (count_reg > NW'(1));

    assign nb1 = nxt(c_reg, count_reg, closed_reg);
    assign nb2 = nxt(nb1, count_reg, closed_reg);
    assign nb3 = nxt(nb2, count_reg, closed_reg);

    psns_mod #(
        .NW(NW)
    ) u_mod (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mod_start),
        .num     (s_query_index[23:12]),
        .den     (count_reg),
        .done_o  (mod_done),
        .rem_o   (mod_rem)
    );

    psns_mac u_mac (
        .aclk    (aclk),
        .aresetn (aresetn),
        .mul_a   (mac_a),
        .mul_b   (mac_b),
        .ctl_i   (mac_ctl),
        .prod_o  (mac_prod),
        .acc_o   (mac_acc),
        .done_o  (mac_done)
    );

    // Operand selection for the shared multiplier.
    always_comb begin
        mac_a   = '0;
        mac_b   = '0;
        mac_ctl = '0;
        pk      = p_reg[step_reg[2:1]][{step_reg[4:3], 5'd0} +: 32];
        p0a     = p_reg[0][{step_reg[1:0], 5'd0} +: 32];
        p1a     = p_reg[1][{step_reg[1:0], 5'd0} +: 32];
        dlin    = {p1a[31], p1a} - {p0a[31], p0a};
        case (state_reg)
            S_WGT: begin
                case (step_reg)
                    5'd0: begin
                        mac_a = psns_pkg::AW'(t_reg);
                        mac_b = psns_pkg::BW'(t_reg);
                    end
                    5'd1: begin
                        mac_a = psns_pkg::AW'(t_reg);
                        mac_b = psns_pkg::BW'(u_w);
                    end
                    5'd2: begin
                        mac_a = psns_pkg::AW'(m1_reg);
                        mac_b = psns_pkg::BW'(u_w);
                    end
                    5'd3: begin
                        mac_a = psns_pkg::AW'(m1_reg);
                        mac_b = psns_pkg::BW'(t_reg);
                    end
                    5'd4: begin
                        mac_a = psns_pkg::AW'(m2_reg);
                        mac_b = psns_pkg::BW'(u_w);
                    end
                    default: begin
                        mac_a = '0;
                    end
                endcase
            end
            S_AXIS: begin
                mac_ctl.acc = 1'b1;
                if (lin_reg) begin
                    mac_a        = psns_pkg::AW'(dlin);
                    mac_b        = psns_pkg::BW'(t_reg);
                    mac_ctl.clr  = 1'b1;
                    mac_ctl.last = 1'b1;
                    mac_ctl.ax   = step_reg[1:0];
                end else begin
                    // High half is signed and weighs 2^16; low half is unsigned.
                    mac_a        = w_reg[step_reg[2:1]];
                    mac_b        = step_reg[0] ? {1'b0, pk[15:0]} : {pk[31], pk[31:16]};
                    mac_ctl.sh   = !step_reg[0];
                    mac_ctl.clr  = (step_reg[2:0] == 3'd0);
                    mac_ctl.last = (step_reg[2:0] == 3'd7);
                    mac_ctl.ax   = step_reg[4:3];
                end
            end
            default: begin
                mac_ctl = '0;
            end
        endcase
    end

    // Cubic weights in units of 2^-36 from the captured products.
    always_comb begin
        m1x = signed'({5'b0, m1_reg, 12'b0});
        t3x = 41'(t3_reg);
        w1x = (41'sd1 <<< 37) - (m1x <<< 2) - m1x + (t3x <<< 1) + t3x;
        w2x = signed'({5'b0, t_reg, 24'b0}) + (m1x <<< 2) - (t3x <<< 1) - t3x;
    end

    // Final scaling of an accumulated axis.
    always_comb begin
        if (lin_reg) begin
            res_val = psns_pkg::sat32(
                psns_pkg::ACCW'(signed'(p_reg[0][{mac_done.ax, 5'd0} +: 32]))
                + ((mac_acc + psns_pkg::LIN_RND) >>> 12));
        end else begin
            res_val = psns_pkg::sat32((mac_acc + psns_pkg::CR_RND) >>> 37);
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    if (s_cmd == psns_pkg::CMD_QUERY && count_reg != '0
                        && count_reg != NW'(1) && closed_reg) begin
                        state_next = S_MOD;
                    end else if (s_cmd == psns_pkg::CMD_QUERY && count_reg != '0
                                 && count_reg != NW'(1) && idx_w > 32'sd0
                                 && idx_w < thr_w) begin
                        state_next = S_NB;
                    end else if (s_cmd == psns_pkg::CMD_QUERY && count_reg != '0) begin
                        state_next = S_FETCH;
                    end else begin
                        state_next = S_DONE;
                    end
                end
            end
            S_MOD: begin
                if (mod_done) begin
                    state_next = S_NB;
                end
            end
            S_NB: begin
                state_next = S_FETCH;
            end
            S_FETCH: begin
                if (fcnt_reg == nfetch) begin
                    if (copy_reg) begin
                        state_next = S_DONE;
                    end else if (lin_reg) begin
                        state_next = S_AXIS;
                    end else begin
                        state_next = S_WGT;
                    end
                end
            end
            S_WGT: begin
                if (step_reg == psns_pkg::WGT_LAST) begin
                    state_next = S_AXIS;
                end
            end
            S_AXIS: begin
                if (step_reg == (lin_reg ? psns_pkg::LIN_LAST : psns_pkg::CR_LAST)) begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (mac_done.acc && mac_done.last && mac_done.ax == 2'd2) begin
                    state_next = S_DONE;
                end
            end
            S_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            closed_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
            fcnt_reg    <= '0;
            step_reg    <= '0;
        end else begin
            state_reg <= state_next;
            if (closed_path_we) begin
                closed_path_we_dummy_guard: begin
                    closed_reg <= closed_path_wdata;
                end
            end
            if (accept && s_cmd == psns_pkg::CMD_APPEND && count_reg < NW'(MAX_NODES)) begin
                count_reg <= count_reg + 1'b1;
            end else if (accept && s_cmd == psns_pkg::CMD_CLEAR) begin
                count_reg <= '0;
            end
            if (state_reg == S_FETCH) begin
                fcnt_reg <= (fcnt_reg == nfetch) ? 3'd0 : fcnt_reg + 1'b1;
            end else begin
                fcnt_reg <= '0;
            end
            if (state_reg == S_WGT || state_reg == S_AXIS) begin
                step_reg <= (state_next != state_reg) ? 5'd0 : step_reg + 1'b1;
            end else begin
                step_reg <= '0;
            end
            if (state_reg == S_DONE && (!m_valid_reg || m_ready)) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Table write on append and registered table read.
    always_ff @(posedge aclk) begin
        if (accept && s_cmd == psns_pkg::CMD_APPEND && count_reg < NW'(MAX_NODES)) begin
            mem[count_reg[IW-1:0]] <= {s_node_z, s_node_y, s_node_x};
        end
        rdata_reg <= mem[rd_addr];
    end

    // Datapath registers.
    always_ff @(posedge aclk) begin
        if (accept) begin
            t_reg      <= s_query_index[11:0];
            lin_reg    <= s_linear_mode;
            copy_reg   <= 1'b0;
            res_x_reg  <= '0;
            res_y_reg  <= '0;
            res_z_reg  <= '0;
            res_st_reg <= psns_pkg::ST_OK;
            c_reg      <= IW'(s_query_index[23:12]);
            nb_reg[0]  <= '0;
            if (s_cmd == psns_pkg::CMD_APPEND && count_reg >= NW'(MAX_NODES)) begin
                res_st_reg <= psns_pkg::ST_FULL;
            end
            if (s_cmd == psns_pkg::CMD_QUERY) begin
                if (count_reg == '0) begin
                    res_st_reg <= psns_pkg::ST_EMPTY;
                end else if (count_reg == NW'(1)) begin
                    copy_reg <= 1'b1;
                end else if (!closed_reg && idx_w <= 32'sd0) begin
                    copy_reg <= 1'b1;
                end else if (!closed_reg && idx_w >= thr_w) begin
                    copy_reg  <= 1'b1;
                    nb_reg[0] <= IW'(count_reg - NW'(2));
                end
            end
        end
        if (state_reg == S_MOD && mod_done) begin
            c_reg <= mod_rem[IW-1:0];
        end
        if (state_reg == S_NB) begin
            nb_reg[0] <= c_reg;
            nb_reg[1] <= nb1;
            nb_reg[2] <= nb2;
            nb_reg[3] <= nb3;
        end
        if (state_reg == S_FETCH && fcnt_reg != 3'd0) begin
            p_reg[fcnt_reg[1:0] - 2'd1] <= rdata_reg;
            if (copy_reg) begin
                res_x_reg <= rdata_reg[31:0];
                res_y_reg <= rdata_reg[63:32];
                res_z_reg <= rdata_reg[95:64];
            end
        end
        if (state_reg == S_WGT) begin
            case (step_reg)
                5'd1: m1_reg  <= mac_prod[23:0];
                5'd2: m2_reg  <= mac_prod[23:0];
                5'd3: t2u_reg <= mac_prod[psns_pkg::AW-1:0];
                5'd4: t3_reg  <= mac_prod[psns_pkg::AW-1:0];
                5'd5: begin
                    w_reg[0] <= -mac_prod[psns_pkg::AW-1:0];
                    w_reg[1] <= w1x[psns_pkg::AW-1:0];
                    w_reg[2] <= w2x[psns_pkg::AW-1:0];
                    w_reg[3] <= -t2u_reg;
                end
                default: begin
                    m1_reg <= m1_reg;
                end
            endcase
        end
        if (mac_done.acc && mac_done.last) begin
            case (mac_done.ax)
                2'd0:    res_x_reg <= res_val;
                2'd1:    res_y_reg <= res_val;
                default: res_z_reg <= res_val;
            endcase
        end
        if (state_reg == S_DONE && (!m_valid_reg || m_ready)) begin
            m_pos_x  <= res_x_reg;
            m_pos_y  <= res_y_reg;
            m_pos_z  <= res_z_reg;
            m_status <= res_st_reg;
        end
    end

    assign m_valid = m_valid_reg;

    // Every accepted word keeps the input side closed in the cycle after it.
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("input accepted back to back");

    // The remainder unit only finishes while the sequencer waits for it.
    a_mod_in_state: assert property (@(posedge aclk) disable iff (!aresetn)
        mod_done |-> (state_reg == S_MOD))
        else $error("remainder finished outside its wait state");

    // A finished axis only arrives while products are in flight.
    a_axis_timing: assert property (@(posedge aclk) disable iff (!aresetn)
        mac_done.last |-> (state_reg == S_AXIS || state_reg == S_DRAIN))
        else $error("axis result arrived out of sequence");

    // A query on an empty path returns the origin.
    a_empty_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status == psns_pkg::ST_EMPTY)
        |-> (m_pos_x == 32'sd0 && m_pos_y == 32'sd0 && m_pos_z == 32'sd0))
        else $error("empty path query returned a nonzero position");

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the path node spline sampler. Every word that is
// accepted on the s_ channel is run through a behavioral model of the
// waypoint table, and the position it should produce is queued. Result words
// on the m_ channel are compared field by field against that queue. Both
// open and closed paths are covered, with directed corner cases followed by
// random build-and-query sequences under random flow control.
// ----------------------------------------------------------------------------
module tb;

    localparam int  NODES      = 256;
    localparam int  ONE        = 4096;
    localparam int  ITEM_GOAL  = 1450;
    localparam int  CYCLE_CAP  = 2000000;
    localparam int  DRAIN_WAIT = 80;

    // Command code that the block does not use.
    localparam logic [1:0] CMD_SPARE = 2'd3;

    typedef struct {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        logic [1:0]         st;
    } pos_word_t;

    // Model of the waypoint table plus the queue of positions still owed
    // by the block.
    class spline_board;
        longint    wp[NODES][3];
        int        count;
        bit        closed;
        pos_word_t owed[$];
        int        errors;

        function new();
            count  = 0;
            closed = 0;
            errors = 0;
        endfunction

        function logic [31:0] clip32(longint v);
            if (v > 64'sd2147483647) return 32'h7fff_ffff;
            if (v < -64'sd2147483648) return 32'h8000_0000;
            return v[31:0];
        endfunction

        function int step_node(int i);
            if (i + 1 > count - 1) return closed ? 0 : i;
            return i + 1;
        endfunction

        // Weighted sum of four nodes on one axis, split into high and low
        // halves so that no partial product overflows 64 bits.
        function longint curve(longint p[4], longint w[4]);
            longint hi_sum, lo_sum, ph, acc;
            hi_sum = 0;
            lo_sum = 0;
            for (int k = 0; k < 4; k++) begin
                ph = p[k] >>> 16;
                hi_sum += w[k] * ph;
                lo_sum += w[k] * (p[k] - ph * 65536);
            end
            acc = hi_sum + (lo_sum >>> 16) + (64'sd1 <<< 20);
            return acc >>> 21;
        endfunction

        function void take_node(int i, ref pos_word_t r);
            r.x = clip32(wp[i][0]);
            r.y = clip32(wp[i][1]);
            r.z = clip32(wp[i][2]);
        endfunction

        function void sample(logic signed [23:0] qi, bit lin, ref pos_word_t r);
            longint idx, period, t, u, d, pos;
            longint w[4];
            longint p[4];
            int     c, nb[4];
            idx = qi;
            if (count == 0) begin
                r.st = psns_pkg::ST_EMPTY;
                return;
            end
            if (count == 1) begin
                take_node(0, r);
                return;
            end
            if (!closed) begin
                if (idx <= 0) begin
                    take_node(0, r);
                    return;
                end
                if (idx >= longint'(count - 3) * ONE) begin
                    take_node(count - 2, r);
                    return;
                end
            end else begin
                period = longint'(count) * ONE;
                idx = idx % period;
                if (idx < 0) idx += period;
            end
            c = int'(idx >> 12);
            if (c >= count) c = count - 1;
            t = idx & (ONE - 1);
            nb[0] = c;
            for (int k = 1; k < 4; k++) nb[k] = step_node(nb[k-1]);
            u = ONE - t;
            w[0] = -(t * u * u);
            w[1] = 2 * ONE * ONE * ONE - 5 * t * t * ONE + 3 * t * t * t;
            w[2] = t * (ONE * ONE + 4 * t * ONE - 3 * t * t);
            w[3] = -(t * t * u);
            for (int ax = 0; ax < 3; ax++) begin
                if (lin) begin
                    d   = wp[nb[1]][ax] - wp[nb[0]][ax];
                    pos = wp[nb[0]][ax] + ((d * t + ONE / 2) >>> 12);
                end else begin
                    for (int k = 0; k < 4; k++) p[k] = wp[nb[k]][ax];
                    pos = curve(p, w);
                end
                case (ax)
                    0: r.x = clip32(pos);
                    1: r.y = clip32(pos);
                    default: r.z = clip32(pos);
                endcase
            end
        endfunction

        function void note_word(logic [1:0] cmd, logic signed [31:0] x,
                                logic signed [31:0] y, logic signed [31:0] z,
                                logic signed [23:0] qi, bit lin);
            pos_word_t r;
            r = '{x: 0, y: 0, z: 0, st: psns_pkg::ST_OK};
            case (cmd)
                psns_pkg::CMD_APPEND: begin
                    if (count < NODES) begin
                        wp[count][0] = x;
                        wp[count][1] = y;
                        wp[count][2] = z;
                        count++;
                    end else begin
                        r.st = psns_pkg::ST_FULL;
                    end
                end
                psns_pkg::CMD_CLEAR: count = 0;
                psns_pkg::CMD_QUERY: sample(qi, lin, r);
                default: ;
            endcase
            owed.push_back(r);
        endfunction

        function void check_word(logic signed [31:0] x, logic signed [31:0] y,
                                 logic signed [31:0] z, logic [1:0] st);
            pos_word_t e;
            if (owed.size() == 0) begin
                $error("unexpected result word");
                errors++;
                return;
            end
            e = owed.pop_front();
            if (x !== e.x) begin
                $error("pos_x expected %0d got %0d", e.x, x);
                errors++;
            end
            if (y !== e.y) begin
                $error("pos_y expected %0d got %0d", e.y, y);
                errors++;
            end
            if (z !== e.z) begin
                $error("pos_z expected %0d got %0d", e.z, z);
                errors++;
            end
            if (st !== e.st) begin
                $error("status expected %0d got %0d", e.st, st);
                errors++;
            end
        endfunction
    endclass

    logic               aclk;
    logic               aresetn;
    logic               closed_path_we;
    logic               closed_path_wdata;
    logic               s_valid;
    logic               s_ready;
    logic [1:0]         s_cmd;
    logic signed [31:0] s_node_x;
    logic signed [31:0] s_node_y;
    logic signed [31:0] s_node_z;
    logic signed [23:0] s_query_index;
    logic               s_linear_mode;
    logic               m_valid;
    logic               m_ready;
    logic signed [31:0] m_pos_x;
    logic signed [31:0] m_pos_y;
    logic signed [31:0] m_pos_z;
    logic [1:0]         m_status;

    spline_board board;
    int          words_sent;
    int          words_back = 0;
    int          cycles = 0;
    bit          steady_send;

    path_node_spline_sampler uut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .closed_path_we    (closed_path_we),
        .closed_path_wdata (closed_path_wdata),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_cmd             (s_cmd),
        .s_node_x          (s_node_x),
        .s_node_y          (s_node_y),
        .s_node_z          (s_node_z),
        .s_query_index     (s_query_index),
        .s_linear_mode     (s_linear_mode),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_pos_x           (m_pos_x),
        .m_pos_y           (m_pos_y),
        .m_pos_z           (m_pos_z),
        .m_status          (m_status)
    );

    always begin
        aclk = 1'b1;
        #5;
        aclk = 1'b0;
        #5;
    end

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_CAP) begin
            $display("tb: done, errors");
            $finish;
        end
    end

    // Result monitor. Outputs are sampled at the rising edge, before the
    // block's own updates for that edge take effect.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            board.check_word(m_pos_x, m_pos_y, m_pos_z, m_status);
            words_back <= words_back + 1;
        end
    end

    // Receiver. It stalls about a quarter of the time, runs without any
    // stall over a window of results, and once holds off for a long stretch
    // so that the output register fills and the block stops taking words.
    initial begin
        bit held;
        held = 0;
        m_ready = 1'b0;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (!held && words_back >= 300) begin
                held = 1;
                m_ready = 1'b0;
                repeat (400) @(negedge aclk);
            end else if (words_back >= 900 && words_back < 1100) begin
                m_ready = 1'b1;
            end else begin
                m_ready = ($urandom_range(0, 99) >= 25);
            end
        end
    end

    // Offer one word and hold it until the block takes it. Payload changes
    // on the falling edge only.
    task automatic send_word(logic [1:0] cmd, logic signed [31:0] x,
                             logic signed [31:0] y, logic signed [31:0] z,
                             logic signed [23:0] qi, bit lin);
        s_cmd         = cmd;
        s_node_x      = x;
        s_node_y      = y;
        s_node_z      = z;
        s_query_index = qi;
        s_linear_mode = lin;
        s_valid       = 1'b1;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        board.note_word(cmd, x, y, z, qi, lin);
        words_sent++;
        @(negedge aclk);
        s_valid = 1'b0;
        if (!steady_send && $urandom_range(0, 99) < 25) begin
            repeat ($urandom_range(1, 6)) @(negedge aclk);
        end
    endtask

    function automatic logic signed [31:0] pick_coord();
        case ($urandom_range(0, 5))
            0: return 32'sh7fff_ffff;
            1: return 32'sh8000_0000;
            2: return $urandom;
            default: return $signed($urandom_range(0, 32'h0040_0000)) - 32'sh0020_0000;
        endcase
    endfunction

    task automatic append_node();
        send_word(psns_pkg::CMD_APPEND, pick_coord(), pick_coord(), pick_coord(),
                  24'($urandom), 1'($urandom_range(0, 1)));
    endtask

    // Query near the populated span most of the time, with the odd index
    // anywhere in the 24-bit range and exact multiples of the node count.
    task automatic query_node();
        int span;
        logic signed [23:0] qi;
        span = (board.count + 2) * ONE;
        case ($urandom_range(0, 9))
            0: qi = 24'($urandom);
            1: qi = 24'(board.count * ONE * (int'($urandom_range(0, 3)) - 1));
            default: qi = 24'(int'($urandom_range(0, 2 * span)) - span / 2);
        endcase
        send_word(psns_pkg::CMD_QUERY, $urandom, $urandom, $urandom, qi,
                  1'($urandom_range(0, 1)));
    endtask

    // The path mode may change only with nothing in flight, so wait for the
    // last result and then for the longest query to finish.
    task automatic set_path_mode(bit closed);
        while (board.owed.size() != 0) @(negedge aclk);
        repeat (DRAIN_WAIT) @(negedge aclk);
        closed_path_we    = 1'b1;
        closed_path_wdata = closed;
        @(negedge aclk);
        closed_path_we    = 1'b0;
        board.closed      = closed;
    endtask

    initial begin
        int phase_goal;
        board             = new();
        words_sent        = 0;
        steady_send       = 0;
        aresetn           = 1'b0;
        closed_path_we    = 1'b0;
        closed_path_wdata = 1'b0;
        s_valid           = 1'b0;
        s_cmd             = psns_pkg::CMD_APPEND;
        s_node_x          = '0;
        s_node_y          = '0;
        s_node_z          = '0;
        s_query_index     = '0;
        s_linear_mode     = 1'b0;
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Directed part: empty path, single node, extremes of coordinates,
        // both clamps of an open path, the unused command code, closed-path wrap and a clear.
        send_word(psns_pkg::CMD_QUERY, 0, 0, 0, 24'sd100, 1'b0);
        send_word(psns_pkg::CMD_APPEND, 32'sh7fff_ffff, 32'sh8000_0000, 0, 24'sd0, 1'b0);
        send_word(psns_pkg::CMD_QUERY, 0, 0, 0, 24'sh7f_ffff, 1'b1);
        send_word(psns_pkg::CMD_APPEND, 32'sh8000_0000, 32'sh7fff_ffff, -1, 24'sd0, 1'b0);
        send_word(psns_pkg::CMD_APPEND, 32'sh7fff_ffff, 32'sh8000_0000, 1, 24'sd0, 1'b1);
        send_word(psns_pkg::CMD_APPEND, 32'sh8000_0000, 32'sh7fff_ffff, 0, 24'sd0, 1'b0);
        send_word(psns_pkg::CMD_APPEND, 32'sh0001_0000, -32'sh0001_0000, 32'sh7fff_ffff,
                  24'sd0, 1'b0);
        send_word(psns_pkg::CMD_QUERY, 0, 0, 0, 24'sh80_0000, 1'b0);
        send_word(psns_pkg::CMD_QUERY, 0, 0, 0, 24'sd0, 1'b1);
        send_word(psns_pkg::CMD_QUERY, 0, 0, 0, 24'sd6144, 1'b0);
        send_word(psns_pkg::CMD_QUERY, 0, 0, 0, 24'sd6144, 1'b1);
        send_word(psns_pkg::CMD_QUERY, 0, 0, 0, 24'sd8191, 1'b0);
        send_word(psns_pkg::CMD_QUERY, 0, 0, 0, 24'sd8192, 1'b0);
        send_word(CMD_SPARE, 32'shffff_ffff, 32'shffff_ffff, 32'shffff_ffff, 24'shff_ffff, 1'b1);
        set_path_mode(1'b1);
        send_word(psns_pkg::CMD_QUERY, 0, 0, 0, 24'sd20480, 1'b0);
        send_word(psns_pkg::CMD_QUERY, 0, 0, 0, 24'sd18000, 1'b0);
        send_word(psns_pkg::CMD_QUERY, 0, 0, 0, -24'sd1, 1'b1);
        send_word(psns_pkg::CMD_QUERY, 0, 0, 0, 24'sh7f_ffff, 1'b0);
        send_word(psns_pkg::CMD_QUERY, 0, 0, 0, 24'sh80_0000, 1'b1);
        send_word(psns_pkg::CMD_CLEAR, 0, 0, 0, 24'sd0, 1'b0);
        send_word(psns_pkg::CMD_QUERY, 0, 0, 0, 24'sd4096, 1'b1);

        // Random part: clear, build a short path, query it, with some noise.
        // Path mode alternates between phases; one phase runs with no sender
        // gaps, and one sequence overfills the table.
        for (int phase = 0; phase < 6; phase++) begin
            set_path_mode(phase[0]);
            steady_send = (phase == 3);
            phase_goal  = words_sent + (ITEM_GOAL - 25) / 6;
            while (words_sent < phase_goal) begin
                send_word(psns_pkg::CMD_CLEAR, $urandom, $urandom, $urandom,
                          24'($urandom), 1'b0);
                if (phase == 2 && board.count == 0 && words_sent + 300 > phase_goal) begin
                    repeat (NODES + 3) append_node();
                end else begin
                    repeat ($urandom_range(0, 7)) append_node();
                end
                repeat ($urandom_range(2, 10)) begin
                    if ($urandom_range(0, 19) == 0) begin
                        send_word(2'($urandom_range(0, 3)), $urandom, $urandom, $urandom,
                                  24'($urandom), 1'($urandom_range(0, 1)));
                    end else begin
                        query_node();
                    end
                end
            end
        end
        steady_send = 0;

        while (board.owed.size() != 0) @(negedge aclk);
        repeat (DRAIN_WAIT) @(negedge aclk);
        if (board.errors == 0 && board.owed.size() == 0) begin
            $display("tb: done, clean");
        end else begin
            $display("tb: done, errors");
        end
        $finish;
    end

endmodule

// ===== files.f =====
sv/psns_pkg.sv
sv/psns_mac.sv
sv/psns_mod.sv
sv/path_node_spline_sampler.sv
tb/tb.sv
